/* rtl/scbs_pkg.sv */
package scbs_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int SAMPLES_DEF    = 20;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCHES_NEEDED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_COLOURS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_CHANNEL   = 3'd7;

    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_LOAD     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SCAN,
        ST_WRITE_OWN,
        ST_WRITE_NBR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic scan_start;
        logic scan_step;
        logic write_load;
        logic write_own;
        logic write_nbr;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic div_done;
        logic scan_done;
        logic do_update;
    } status_t;

endpackage

/* rtl/scbs_ctrl.sv */
module scbs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  scbs_pkg::status_t status,
    output scbs_pkg::cmd_t    cmd,
    output logic              busy
);

    scbs_pkg::state_t state_reg;
    scbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scbs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = scbs_pkg::ST_PREP;
                end
            end
            scbs_pkg::ST_PREP:
            begin
                // The item holds here until the previous result has left.
                if (out_free)
                begin
                    if (status.is_load)
                    begin
                        state_next = scbs_pkg::ST_WRITE_OWN;
                    end
                    else
                    begin
                        state_next = scbs_pkg::ST_DIV;
                    end
                end
            end
            scbs_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = scbs_pkg::ST_SCAN;
                end
            end
            scbs_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.do_update)
                    begin
                        state_next = scbs_pkg::ST_WRITE_OWN;
                    end
                    else
                    begin
                        state_next = scbs_pkg::ST_DONE;
                    end
                end
            end
            scbs_pkg::ST_WRITE_OWN:
            begin
                if (status.is_load)
                begin
                    state_next = scbs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = scbs_pkg::ST_WRITE_NBR;
                end
            end
            scbs_pkg::ST_WRITE_NBR:
            begin
                state_next = scbs_pkg::ST_DONE;
            end
            scbs_pkg::ST_DONE:
            begin
                state_next = scbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            scbs_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = in_fire;
            end
            scbs_pkg::ST_PREP:
            begin
                cmd.prep       = 1'b1;
                cmd.div_start  = !status.is_load;
            end
            scbs_pkg::ST_DIV:
            begin
                cmd.scan_start = status.div_done;
            end
            scbs_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            scbs_pkg::ST_WRITE_OWN:
            begin
                cmd.write_load = status.is_load;
                cmd.write_own  = !status.is_load;
            end
            scbs_pkg::ST_WRITE_NBR:
            begin
                cmd.write_nbr = 1'b1;
            end
            scbs_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/scbs_datapath.sv */
module scbs_datapath
#(
    parameter int MAX_WIDTH  = scbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scbs_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLES    = scbs_pkg::SAMPLES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  scbs_pkg::cmd_t    cmd,
    output scbs_pkg::status_t status,
    input  logic [82:0]       in_data,
    input  logic [4:0]        sample_count,
    input  logic [7:0]        match_threshold,
    input  logic [4:0]        matches_needed,
    input  logic [15:0]       update_factor,
    input  logic [15:0]       seg_colours,
    input  logic [9:0]        frame_width,
    input  logic [9:0]        frame_height,
    input  logic              three_channel,
    output logic [7:0]        seg_value,
    output logic              is_foreground
);

    localparam int XW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int KW   = (SAMPLES    > 1) ? $clog2(SAMPLES)    : 1;
    localparam int KCW  = $clog2(SAMPLES + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * SAMPLES;
    localparam int AW   = $clog2(DEPTH);
    localparam int XCW  = $clog2(MAX_WIDTH + 1);
    localparam int YCW  = $clog2(MAX_HEIGHT + 1);

    // Model memory: one 24-bit sample per address, one port.
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [23:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Captured item.
    logic        func_reg;
    logic [8:0]  px_raw_reg;
    logic [8:0]  py_raw_reg;
    logic [4:0]  slot_reg;
    logic [23:0] colour_reg;
    logic [15:0] rupd_reg;
    logic [15:0] rmem_reg;
    logic [2:0]  rdir_reg;

    // Prepared values.
    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic [XCW-1:0] w_reg;
    logic [YCW-1:0] h_reg;
    logic [KCW-1:0] n_reg;
    logic [AW-1:0]  base_reg;
    logic           slot_ok_reg;

    // Serial remainder unit shared by both modulo draws.
    logic [15:0] rem_u_reg;
    logic [15:0] rem_m_reg;
    logic [15:0] f_reg;
    logic [4:0]  bit_reg;
    logic        div_busy_reg;
    logic        div_done_reg;

    // Scan state.
    logic [KCW-1:0] k_reg;
    logic           rd_valid_reg;
    logic [4:0]     count_reg;
    logic           bg_reg;
    logic           scan_done_reg;
    logic [KW-1:0]  m_reg;

    logic [7:0]  seg_reg;
    logic        fg_reg;

    // Clamped position and effective sizes.
    logic [XCW-1:0] w_eff;
    logic [YCW-1:0] h_eff;
    logic [KCW-1:0] n_eff;
    logic [XCW-1:0] x_ext;
    logic [YCW-1:0] y_ext;

    always_comb
    begin
        if (frame_width == 10'd0)
        begin
            w_eff = XCW'(1);
        end
        else if ({22'd0, frame_width} > 32'(MAX_WIDTH))
        begin
            w_eff = XCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = XCW'(frame_width);
        end
        if (frame_height == 10'd0)
        begin
            h_eff = YCW'(1);
        end
        else if ({22'd0, frame_height} > 32'(MAX_HEIGHT))
        begin
            h_eff = YCW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = YCW'(frame_height);
        end
        if (sample_count == 5'd0)
        begin
            n_eff = KCW'(1);
        end
        else if ({27'd0, sample_count} > 32'(SAMPLES))
        begin
            n_eff = KCW'(SAMPLES);
        end
        else
        begin
            n_eff = KCW'(sample_count);
        end
        if ({23'd0, px_raw_reg} >= 32'(w_eff))
        begin
            x_ext = w_eff - XCW'(1);
        end
        else
        begin
            x_ext = XCW'(px_raw_reg);
        end
        if ({23'd0, py_raw_reg} >= 32'(h_eff))
        begin
            y_ext = h_eff - YCW'(1);
        end
        else
        begin
            y_ext = YCW'(py_raw_reg);
        end
    end

    // Neighbour position.
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          can_r;
    logic          can_d;
    logic          can_l;
    logic          can_u;

    always_comb
    begin
        can_r = (XCW'(x_reg) + XCW'(1)) < w_reg;
        can_d = (YCW'(y_reg) + YCW'(1)) < h_reg;
        can_l = x_reg != '0;
        can_u = y_reg != '0;
        nx = x_reg;
        ny = y_reg;
        unique case (rdir_reg)
            3'd0:
            begin
                if (can_r) nx = x_reg + XW'(1);
            end
            3'd1:
            begin
                if (can_r) nx = x_reg + XW'(1);
                if (can_d) ny = y_reg + YW'(1);
            end
            3'd2:
            begin
                if (can_d) ny = y_reg + YW'(1);
            end
            3'd3:
            begin
                if (can_l) nx = x_reg - XW'(1);
                if (can_d) ny = y_reg + YW'(1);
            end
            3'd4:
            begin
                if (can_l) nx = x_reg - XW'(1);
            end
            3'd5:
            begin
                if (can_l) nx = x_reg - XW'(1);
                if (can_u) ny = y_reg - YW'(1);
            end
            3'd6:
            begin
                if (can_u) ny = y_reg - YW'(1);
            end
            default:
            begin
                if (can_r) nx = x_reg + XW'(1);
                if (can_u) ny = y_reg - YW'(1);
            end
        endcase
    end

    // Pixel base addresses (two constant-factor multiplies each).
    logic [AW-1:0] nbr_base;
    assign nbr_base = AW'((32'(ny) * 32'(MAX_WIDTH) + 32'(nx)) * 32'(SAMPLES));

    // Match test against the registered sample.
    logic [7:0] s0, s1, s2;
    logic [7:0] d0, d1, d2;
    logic [9:0] dsum;
    logic [9:0] thr3;
    logic       hit;

    always_comb
    begin
        s0 = rd_data_reg[7:0];
        s1 = rd_data_reg[15:8];
        s2 = rd_data_reg[23:16];
        d0 = (colour_reg[7:0]   > s0) ? colour_reg[7:0]   - s0 : s0 - colour_reg[7:0];
        d1 = (colour_reg[15:8]  > s1) ? colour_reg[15:8]  - s1 : s1 - colour_reg[15:8];
        d2 = (colour_reg[23:16] > s2) ? colour_reg[23:16] - s2 : s2 - colour_reg[23:16];
        dsum = {2'd0, d0} + {2'd0, d1} + {2'd0, d2};
        thr3 = {2'd0, match_threshold} + {1'b0, match_threshold, 1'b0};
        if (three_channel)
        begin
            hit = dsum < thr3;
        end
        else
        begin
            hit = d0 < match_threshold;
        end
    end

    logic [4:0] count_inc;
    assign count_inc = count_reg + 5'd1;

    // Restoring remainder step.
    logic [16:0] tu, tm;
    logic [16:0] nm;
    assign tu = {rem_u_reg, rupd_reg[bit_reg[3:0]]};
    assign tm = {rem_m_reg, rmem_reg[bit_reg[3:0]]};
    assign nm = 17'(n_reg);

    logic last_k;
    assign last_k = (k_reg + KCW'(1)) == n_reg;

    // Memory address and write selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = colour_reg;
        mem_addr  = base_reg + AW'(k_reg);
        if (cmd.write_load)
        begin
            mem_we   = slot_ok_reg;
            mem_addr = base_reg + AW'(slot_reg);
        end
        else if (cmd.write_own)
        begin
            mem_we   = 1'b1;
            mem_addr = base_reg + AW'(m_reg);
        end
        else if (cmd.write_nbr)
        begin
            mem_we   = 1'b1;
            mem_addr = nbr_base + AW'(m_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_data[0];
            px_raw_reg <= in_data[9:1];
            py_raw_reg <= in_data[18:10];
            slot_reg   <= in_data[23:19];
            colour_reg <= in_data[47:24];
            rupd_reg   <= in_data[63:48];
            rmem_reg   <= in_data[79:64];
        end
        if (cmd.prep)
        begin
            x_reg       <= XW'(x_ext);
            y_reg       <= YW'(y_ext);
            w_reg       <= w_eff;
            h_reg       <= h_eff;
            n_reg       <= n_eff;
            base_reg    <= AW'((32'(y_ext) * 32'(MAX_WIDTH) + 32'(x_ext)) * 32'(SAMPLES));
            slot_ok_reg <= {27'd0, slot_reg} < 32'(SAMPLES);
            f_reg       <= (update_factor == 16'd0) ? 16'd1 : update_factor;
        end
        if (cmd.div_start)
        begin
            rem_u_reg <= '0;
            rem_m_reg <= '0;
            bit_reg   <= 5'd15;
        end
        else if (div_busy_reg)
        begin
            rem_u_reg <= (tu >= {1'b0, f_reg}) ? 16'(tu - {1'b0, f_reg}) : tu[15:0];
            rem_m_reg <= (tm >= nm) ? 16'(tm - nm) : tm[15:0];
            bit_reg   <= bit_reg - 5'd1;
        end
        if (cmd.scan_start)
        begin
            k_reg     <= '0;
            count_reg <= '0;
            bg_reg    <= 1'b0;
            m_reg     <= KW'(rem_m_reg);
        end
        else if (cmd.scan_step && !scan_done_reg)
        begin
            if (rd_valid_reg)
            begin
                if (hit && !bg_reg)
                begin
                    count_reg <= count_inc;
                    if (count_inc >= matches_needed)
                    begin
                        bg_reg <= 1'b1;
                    end
                end
                k_reg <= k_reg + KCW'(1);
            end
        end
        if (cmd.write_load)
        begin
            seg_reg <= 8'd0;
            fg_reg  <= 1'b0;
        end
        else if (cmd.scan_step && scan_done_reg)
        begin
            seg_reg <= bg_reg ? seg_colours[7:0] : seg_colours[15:8];
            fg_reg  <= !bg_reg;
        end
    end

    // Direction draw: low three bits, kept separately.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rdir_reg <= in_data[82:80];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            scan_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg && bit_reg == 5'd0)
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                rd_valid_reg  <= 1'b0;
                scan_done_reg <= 1'b0;
            end
            else if (cmd.scan_step && !scan_done_reg)
            begin
                // Read issued in one cycle, compared in the next.
                rd_valid_reg <= !rd_valid_reg;
                if (rd_valid_reg && ((hit && count_inc >= matches_needed) || last_k || bg_reg))
                begin
                    scan_done_reg <= 1'b1;
                end
            end
            else if (!cmd.scan_step)
            begin
                scan_done_reg <= 1'b0;
            end
        end
    end

    logic bg_final;
    assign bg_final = bg_reg;

    assign status.is_load   = (func_reg == scbs_pkg::FUNC_LOAD);
    assign status.div_done  = div_done_reg;
    assign status.scan_done = scan_done_reg;
    assign status.do_update = bg_final && (rem_u_reg == f_reg - 16'd1);

    assign seg_value     = seg_reg;
    assign is_foreground = fg_reg;

endmodule

/* rtl/sample_consensus_background_subtract.sv */
// Channel  | Direction | Handshake               | Contents
// s_axis   | in        | s_axis_tvalid/tready    | one load or classify item
// m_axis   | out       | m_axis_tvalid/tready    | segmentation byte and flag
// cfg      | in        | cfg_valid/cfg_ready     | register index and value
//
// One item at a time. A load passes through accept, prepare, write and finish.
// A classify passes through accept and prepare, the serial remainder unit (16
// bit steps and a done step), then reads each stored sample from the single-port
// model memory and compares it, until the match count is reached or the samples
// run out; it then registers the result, makes the own and neighbour writes when
// the model updates, and finishes.
// Reset clears the controller and the register file; the model memory is not
// cleared, and every sample must be loaded before it is read. A result waits in
// the output register; the next item may be accepted meanwhile, but it holds in
// its prepare step until that result's transfer has taken place.
module sample_consensus_background_subtract
#(
    parameter int MAX_WIDTH  = scbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scbs_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLES    = scbs_pkg::SAMPLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: pixel_x, pixel_y, slot, chan0, chan1, chan2,
    // rand_update, rand_member, rand_direction, zero fill
    input  logic [95:0] s_axis_tdata,
    // tuser: func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: seg_value
    output logic [7:0]  m_axis_tdata,
    // tuser: is_foreground
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [4:0]  sample_count_reg;
    logic [7:0]  match_threshold_reg;
    logic [4:0]  matches_needed_reg;
    logic [15:0] update_factor_reg;
    logic [15:0] seg_colours_reg;
    logic [9:0]  frame_width_reg;
    logic [9:0]  frame_height_reg;
    logic        three_channel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg    <= 5'd20;
            match_threshold_reg <= 8'd20;
            matches_needed_reg  <= 5'd2;
            update_factor_reg   <= 16'd16;
            seg_colours_reg     <= 16'hFF00;
            frame_width_reg     <= 10'd512;
            frame_height_reg    <= 10'd512;
            three_channel_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scbs_pkg::REG_SAMPLE_COUNT:    sample_count_reg    <= cfg_data[4:0];
                scbs_pkg::REG_MATCH_THRESHOLD: match_threshold_reg <= cfg_data[7:0];
                scbs_pkg::REG_MATCHES_NEEDED:  matches_needed_reg  <= cfg_data[4:0];
                scbs_pkg::REG_UPDATE_FACTOR:   update_factor_reg   <= cfg_data;
                scbs_pkg::REG_SEG_COLOURS:     seg_colours_reg     <= cfg_data;
                scbs_pkg::REG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[9:0];
                scbs_pkg::REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[9:0];
                scbs_pkg::REG_THREE_CHANNEL:   three_channel_reg   <= cfg_data[0];
            endcase
        end
    end

    scbs_pkg::cmd_t    cmd;
    scbs_pkg::status_t status;
    logic              busy;
    logic              in_fire;
    logic              out_valid_reg;
    logic [82:0]       item;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // Datapath order: func, position, slot, colour, draws (direction's low bits).
    assign item = {s_axis_tdata[81:0], s_axis_tuser};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write_load || (cmd.scan_step && status.scan_done))
        begin
            out_valid_reg <= 1'b1;
        end
    end

    scbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!out_valid_reg),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    scbs_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SAMPLES    (SAMPLES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_data         (item),
        .sample_count    (sample_count_reg),
        .match_threshold (match_threshold_reg),
        .matches_needed  (matches_needed_reg),
        .update_factor   (update_factor_reg),
        .seg_colours     (seg_colours_reg),
        .frame_width     (frame_width_reg),
        .frame_height    (frame_height_reg),
        .three_channel   (three_channel_reg),
        .seg_value       (m_axis_tdata),
        .is_foreground   (m_axis_tuser)
    );

    assign m_axis_tvalid = out_valid_reg;

endmodule
